[rtl/mavc_pkg.sv]
// Package: types and constants for the moving average with confidence block.
package mavc_pkg;

	localparam int unsigned MAX_WINDOW_DEF  = 64;
	localparam int unsigned SAMPLE_BITS_DEF = 32;

	localparam int unsigned WLEN_BITS = 7;
	localparam int unsigned EDIF_BITS = 32;
	localparam int unsigned CFG_BITS  = 32;
	localparam int unsigned AVG_BITS  = 32;
	localparam int unsigned CONF_BITS = 15;
	localparam int unsigned SIG_BITS  = 25;

	localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd10;
	localparam logic [EDIF_BITS-1:0] EDIF_RESET = 32'd393;

	localparam logic CFG_IDX_WLEN = 1'b0;
	localparam logic CFG_IDX_EDIF = 1'b1;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	localparam logic [CONF_BITS-1:0] FULL_CONF      = 15'd25600;
	localparam logic [SIG_BITS-1:0]  NOT_FULL_SIG   = 25'h1FB0000;
	localparam logic [23:0]          SIGMA_SAT      = 24'hFFFFFF;
	localparam logic [23:0]          THREE_SIGMAS   = 24'd196608;

	typedef struct packed {
		logic                       func;
		logic [SAMPLE_BITS_DEF-1:0] sample;
	} mavc_in_t;

	typedef struct packed {
		logic [AVG_BITS-1:0]  average;
		logic                 window_full;
		logic [CONF_BITS-1:0] confidence;
		logic [SIG_BITS-1:0]  sigmas_away;
	} mavc_out_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} mavc_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
		logic [63:0] rem;
	} mavc_div_rsp_t;

endpackage

[rtl/moving_average_with_confidence.sv]
// Top level: boxcar moving average with outlier confidence over a sample ring memory.
// Sequence per request: a clear returns its result directly; a sample reads the ring entry,
// writes the new sample back and, before the window fills, returns; once full it then runs
// two divisions in one shared divider (mean, then sigma ratio), and with a zero divisor
// only the mean division.
// Throughput: one request at a time; the next is taken the cycle after the result leaves.
// Reset: window empty, registers at defaults; ring contents undefined and never read unwritten.
module moving_average_with_confidence
	import mavc_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  mavc_in_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mavc_out_t           out_data
);

	localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int unsigned PTR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned CNT_BITS = $clog2(MAX_WINDOW + 1);
	localparam int unsigned SUM_BITS = SAMPLE_BITS + CNT_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_UPDATE, ST_MEAN, ST_DEV, ST_SIG, ST_WAIT, ST_OUT
	} state_t;

	state_t state_q;

	logic [WLEN_BITS-1:0]   wlen_q;
	logic [EDIF_BITS-1:0]   edif_q;
	logic signed [SUM_BITS-1:0] sum_q;
	logic [CNT_BITS-1:0]    fill_q;
	logic [PTR_BITS-1:0]    wptr_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SUM_BITS-1:0] avg_q;
	logic                   neg_q;
	logic [23:0]            sig_q;
	mavc_out_t              res_q;
	logic                   res_valid_q;

	// Ring memory with a registered read
	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic                          ring_we;

	mavc_div_req_t div_req;
	mavc_div_rsp_t div_rsp;

	logic [CNT_BITS-1:0] len;
	logic [PTR_BITS-1:0] ptr;
	logic                in_take;
	logic signed [SUM_BITS-1:0] sum_nxt;
	logic [CNT_BITS-1:0] fill_nxt;
	logic [63:0]         q_round;
	logic signed [SUM_BITS:0] dev;
	logic [SUM_BITS:0]   dev_abs;
	logic [33:0]         div3;
	logic [23:0]         s_sat;
	logic [31:0]         ded;
	logic [CONF_BITS-1:0] conf;

	// Effective window length: 0 acts as 1, clamp at MAX_WINDOW
	always_comb begin
		if (wlen_q == '0) begin
			len = CNT_BITS'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			len = CNT_BITS'(MAX_WINDOW);
		end else begin
			len = CNT_BITS'(wlen_q);
		end
	end

	assign ptr      = (32'(wptr_q) >= 32'(len)) ? '0 : wptr_q;
	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || res_valid_q;
	assign ring_we  = (state_q == ST_UPDATE);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[ptr] <= x_q;
		end
		rd_s1 <= ring[ptr];
	end

	// Sum and fill count after this sample
	always_comb begin
		sum_nxt  = sum_q + SUM_BITS'(x_q);
		fill_nxt = fill_q;
		if (fill_q >= len) begin
			sum_nxt = sum_nxt - SUM_BITS'(rd_s1);
		end else begin
			fill_nxt = fill_q + CNT_BITS'(1);
		end
	end

	assign q_round = div_rsp.quo;
	assign dev     = (SUM_BITS+1)'(x_q) - (SUM_BITS+1)'(avg_q);
	assign dev_abs = dev[SUM_BITS] ? (SUM_BITS+1)'(-dev) : (SUM_BITS+1)'(dev);
	assign div3    = {2'b0, edif_q} + {1'b0, edif_q, 1'b0};

	// Round the sigma quotient and saturate
	always_comb begin
		logic [63:0] s;
		s = div_rsp.quo;
		if ({1'b0, div_rsp.rem} >= 65'(div3) - 65'(div3 >> 1)) begin
			s = s + 64'd1;
		end
		s_sat = (s > 64'(SIGMA_SAT)) ? SIGMA_SAT : s[23:0];
	end

	// Confidence from the sigma count: divide by 768 as >>8 then by 3
	always_comb begin
		logic [31:0] t;
		t    = (32'(sig_q) * 32'd100 + 32'd384) >> 8;
		ded  = 32'((33'(t) * 33'd43691) >> 17);
		if (32'(ded) * 32'd3 > t) begin
			ded = ded - 32'd1;
		end
		if (sig_q >= THREE_SIGMAS || ded >= 32'(FULL_CONF)) begin
			conf = '0;
		end else begin
			conf = FULL_CONF - CONF_BITS'(ded);
		end
	end

	// Sequencer: read old entry, update, up to two divisions, result; a clear returns at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= WLEN_RESET;
			edif_q      <= EDIF_RESET;
			sum_q       <= '0;
			fill_q      <= '0;
			wptr_q      <= '0;
			res_valid_q <= 1'b0;
			div_req     <= '0;
		end else begin
			div_req.start <= 1'b0;
			if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IDX_WLEN: wlen_q <= cfg_wdata[WLEN_BITS-1:0];
					CFG_IDX_EDIF: edif_q <= cfg_wdata[EDIF_BITS-1:0];
					default: ;
				endcase
				sum_q  <= '0;
				fill_q <= '0;
				wptr_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (in_data.func == FUNC_CLEAR) begin
							sum_q  <= '0;
							fill_q <= '0;
							wptr_q <= '0;
							res_q.average     <= '0;
							res_q.window_full <= 1'b0;
							res_q.confidence  <= FULL_CONF;
							res_q.sigmas_away <= NOT_FULL_SIG;
							res_valid_q       <= 1'b1;
						end else begin
							x_q     <= SAMPLE_BITS'(in_data.sample);
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					sum_q  <= sum_nxt;
					fill_q <= fill_nxt;
					wptr_q <= (32'(ptr) + 1 >= 32'(len)) ? '0 : ptr + PTR_BITS'(1);
					if (fill_nxt >= len) begin
						state_q <= ST_MEAN;
					end else begin
						res_q.average     <= AVG_BITS'(x_q);
						res_q.window_full <= 1'b0;
						res_q.confidence  <= FULL_CONF;
						res_q.sigmas_away <= NOT_FULL_SIG;
						state_q           <= ST_OUT;
					end
				end
				ST_MEAN: begin
					neg_q <= sum_q[SUM_BITS-1];
					div_req.start <= 1'b1;
					div_req.num   <= 64'(sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q))
						+ 64'(len >> 1);
					div_req.den   <= 64'(len);
					state_q       <= ST_DEV;
				end
				ST_DEV: begin
					if (div_rsp.done) begin
						avg_q <= neg_q ? -SUM_BITS'(q_round) : SUM_BITS'(q_round);
						state_q <= ST_SIG;
					end
				end
				// Start the sigma division, or skip it on a zero divisor
				ST_SIG: begin
					if (div3 == '0) begin
						sig_q   <= '0;
						state_q <= ST_OUT;
						res_q.average     <= AVG_BITS'(avg_q);
						res_q.window_full <= 1'b1;
					end else begin
						div_req.start <= 1'b1;
						div_req.num   <= 64'(dev_abs) << 16;
						div_req.den   <= 64'(div3);
						state_q       <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						sig_q   <= s_sat;
						state_q <= ST_OUT;
						res_q.average     <= AVG_BITS'(avg_q);
						res_q.window_full <= 1'b1;
					end
				end
				ST_OUT: begin
					if (res_q.window_full) begin
						res_q.confidence  <= conf;
						res_q.sigmas_away <= SIG_BITS'(sig_q);
					end
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mavc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("input taken while busy");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_WINDOW) else $error("fill count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && out_stall) |=> res_valid_q) else $error("result dropped");

endmodule

[rtl/mavc_div.sv]
// Module: restoring radix-2 divider, one quotient bit per cycle while busy.
module mavc_div
	import mavc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  mavc_div_req_t req,
	output mavc_div_rsp_t rsp
);

	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	// Shift in the next numerator bit and try a subtract
	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("divider did not start");

endmodule

[test/moving_average_with_confidence_tb.sv]
// Testbench: random and directed requests against a built-in predictor of the moving average block.
`timescale 1ns / 1ps

module moving_average_with_confidence_tb
	import mavc_pkg::*;
;

	localparam int unsigned RING_DEPTH = 64;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [CFG_BITS-1:0] cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	mavc_in_t            in_data;
	logic                out_valid;
	logic                out_stall;
	mavc_out_t           out_data;

	moving_average_with_confidence u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Predictor copy of the configuration and window state
	logic [WLEN_BITS-1:0] win_len_reg;
	logic [EDIF_BITS-1:0] exp_diff_reg;
	logic signed [31:0]   ring_q [RING_DEPTH];
	longint               window_sum;
	int unsigned          window_fill;
	int unsigned          ring_wr;

	mavc_in_t  pending_reqs [$];
	mavc_out_t expected_avgs [$];
	int        error_count;
	int        result_count;
	int        full_count;
	int        hold_cycles;
	bit        drain_req;

	initial begin
		clk = 1'b0;
	end
	always #10 clk = ~clk;

	// Empty the predicted window
	function automatic void empty_predicted_window();
		window_sum  = 0;
		window_fill = 0;
		ring_wr     = 0;
	endfunction

	// Compute the expected result of one request and advance the window
	function automatic mavc_out_t average_and_confidence(mavc_in_t req);
		mavc_out_t   res;
		int unsigned len;
		longint      x;
		longint      avg;
		longint      mag;
		longint      q;
		longint unsigned dev;
		longint unsigned divisor;
		longint unsigned num;
		longint unsigned sig;
		longint unsigned ded;
		res.average     = '0;
		res.window_full = 1'b0;
		res.confidence  = FULL_CONF;
		res.sigmas_away = NOT_FULL_SIG;
		if (req.func == FUNC_CLEAR) begin
			empty_predicted_window();
			return res;
		end
		len = (win_len_reg == 0) ? 1 : (win_len_reg > RING_DEPTH ? RING_DEPTH : win_len_reg);
		x = longint'($signed(req.sample));
		if (ring_wr >= len)
			ring_wr = 0;
		if (window_fill >= len)
			window_sum -= ring_q[ring_wr];
		ring_q[ring_wr] = req.sample;
		window_sum += x;
		ring_wr = (ring_wr + 1 >= len) ? 0 : ring_wr + 1;
		if (window_fill < len)
			window_fill++;
		if (window_fill < len) begin
			res.average = req.sample;
			return res;
		end
		// Mean rounded to nearest, ties away from zero
		mag = (window_sum < 0) ? -window_sum : window_sum;
		q = (mag + len / 2) / len;
		avg = (window_sum < 0) ? -q : q;
		dev = (x >= avg) ? longint'(x - avg) : longint'(avg - x);
		divisor = longint'(exp_diff_reg) * 3;
		sig = 0;
		if (divisor != 0) begin
			num = dev << 16;
			sig = num / divisor;
			if (num % divisor >= divisor - divisor / 2)
				sig++;
			if (sig > SIGMA_SAT)
				sig = SIGMA_SAT;
		end
		if (sig >= THREE_SIGMAS) begin
			res.confidence = '0;
		end else begin
			ded = (sig * 100 + 384) / 768;
			res.confidence = (ded >= FULL_CONF) ? '0 : CONF_BITS'(FULL_CONF - ded);
		end
		res.average     = avg[31:0];
		res.window_full = 1'b1;
		res.sigmas_away = sig[SIG_BITS-1:0];
		return res;
	endfunction

	// Queue one request
	task automatic push_request(logic func, logic [31:0] sample);
		mavc_in_t req;
		req.func   = func;
		req.sample = sample;
		pending_reqs.insert(pending_reqs.size(), req);
	endtask

	// Wait until the block has drained, then write one register
	task automatic write_register(logic idx, logic [CFG_BITS-1:0] value);
		wait (pending_reqs.size() == 0 && !in_valid && expected_avgs.size() == 0);
		repeat (160) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_WLEN)
			win_len_reg = value[WLEN_BITS-1:0];
		else
			exp_diff_reg = value;
		empty_predicted_window();
	endtask

	// Driver: offer queued requests with random gaps
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_avgs.insert(expected_avgs.size(), average_and_confidence(in_data));
			end
			if (in_valid && in_stall) begin
				// hold the stalled request
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() > 0 && !drain_req) begin
				in_valid <= 1'b1;
				in_data  <= pending_reqs[0];
				pending_reqs.delete(0);
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check results and draw receiver stalls
	always @(posedge clk or negedge arst_n) begin
		mavc_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_avgs.size() == 0) begin
					$display("%0t: expected no result, actual %h", $time, out_data);
					error_count++;
				end else begin
					want = expected_avgs[0];
					expected_avgs.delete(0);
					if (out_data.window_full)
						full_count++;
					if (out_data.average !== want.average)
						$display("%0t: average expected %h actual %h", $time,
							want.average, out_data.average);
					if (out_data.window_full !== want.window_full)
						$display("%0t: window_full expected %b actual %b", $time,
							want.window_full, out_data.window_full);
					if (out_data.confidence !== want.confidence)
						$display("%0t: confidence expected %0d actual %0d", $time,
							want.confidence, out_data.confidence);
					if (out_data.sigmas_away !== want.sigmas_away)
						$display("%0t: sigmas_away expected %h actual %h", $time,
							want.sigmas_away, out_data.sigmas_away);
					if (out_data !== want)
						error_count++;
				end
			end
			if (hold_cycles > 0) begin
				out_stall   <= 1'b1;
				hold_cycles <= hold_cycles - 1;
			end else if ($urandom_range(0, 7) < 3) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Random sample with a bias toward values near a base level
	function automatic logic [31:0] near_sample(logic [31:0] base, int unsigned spread);
		return base + $urandom_range(0, spread) - spread / 2;
	endfunction

	// Stimulus
	initial begin
		logic [31:0] base;
		int unsigned n;
		cfg_we       = 1'b0;
		cfg_index    = CFG_IDX_WLEN;
		cfg_wdata    = '0;
		drain_req    = 1'b0;
		hold_cycles  = 0;
		error_count  = 0;
		result_count = 0;
		full_count   = 0;
		win_len_reg  = WLEN_RESET;
		exp_diff_reg = EDIF_RESET;
		empty_predicted_window();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes at reset settings, clear items, outliers
		push_request(FUNC_CLEAR, 32'h0);
		for (int i = 0; i < 10; i++)
			push_request(FUNC_SAMPLE, (i % 2) ? 32'h7FFFFFFF : 32'h80000000);
		push_request(FUNC_SAMPLE, 32'hFFFFFFFF);
		push_request(FUNC_SAMPLE, 32'h00010000);
		push_request(FUNC_CLEAR, 32'hFFFFFFFF);
		for (int i = 0; i < 10; i++)
			push_request(FUNC_SAMPLE, 32'h00050000 + i * 100);
		push_request(FUNC_SAMPLE, 32'h00050000);

		// Zero divisor, then a window of one and the widest window
		write_register(CFG_IDX_EDIF, 32'h0);
		write_register(CFG_IDX_WLEN, 32'd1);
		for (int i = 0; i < 4; i++)
			push_request(FUNC_SAMPLE, $urandom());
		write_register(CFG_IDX_EDIF, 32'hFFFFFFFF);
		write_register(CFG_IDX_WLEN, 32'd0);
		for (int i = 0; i < 4; i++)
			push_request(FUNC_SAMPLE, $urandom());
		write_register(CFG_IDX_WLEN, 32'd127);
		for (int i = 0; i < 70; i++)
			push_request(FUNC_SAMPLE, $urandom());

		// Random phases across several settings
		for (int ph = 0; ph < 12; ph++) begin
			write_register(CFG_IDX_WLEN, (ph == 3) ? 32'd64 : $urandom_range(1, 12));
			write_register(CFG_IDX_EDIF, (ph % 4 == 0) ? $urandom() : $urandom_range(0, 2000));
			base = $urandom();
			for (int i = 0; i < 137; i++) begin
				n = $urandom_range(0, 99);
				if (n < 2)
					push_request(FUNC_CLEAR, $urandom());
				else if (n < 12)
					push_request(FUNC_SAMPLE, $urandom());
				else
					push_request(FUNC_SAMPLE, near_sample(base, 1 << $urandom_range(4, 20)));
			end
			// Long receiver hold while the sender keeps offering
			if (ph == 2)
				hold_cycles = 600;
			// Sender pauses until every result has come
			if (ph == 5) begin
				wait (pending_reqs.size() == 0);
				drain_req = 1'b1;
				wait (!in_valid && expected_avgs.size() == 0);
				drain_req = 1'b0;
			end
		end

		wait (pending_reqs.size() == 0 && !in_valid && expected_avgs.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d results, %0d with a full window, over window lengths 1..64,",
			result_count, full_count);
		$display("zero and maximum spreads, clears and reconfiguration between phases.");
		if (error_count == 0 && expected_avgs.size() == 0)
			$display("moving_average_with_confidence: match");
		else
			$display("moving_average_with_confidence: mismatch");
		$finish;
	end

	// Timeout
	initial begin
		#40ms;
		$display("moving_average_with_confidence: mismatch");
		$finish;
	end

endmodule
